// File: hw/rtl/hpr_pkg.sv
// Shared constants, types and saturation helper for the packed rank-1 update block.
package hpr_pkg;

  // Data word and vector store geometry
  localparam int WORD_W    = 32;
  localparam int MAX_ORDER = 64;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ORDER_W   = 7;
  localparam int FRAC_BITS = 24;
  localparam int ENTRY_W   = 2 * WORD_W;

  // Datapath widths: full product, shifted product, three-term sum
  localparam int PROD_W = 2 * WORD_W;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int ACC_W  = SH_W + 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_TRIANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_REVERSED     = 2'd3;

  // Item operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Multiply steps of one update, issued in this order
  typedef enum logic [2:0] {
    MS_ALPHA_CRE = 3'd0,  // alpha * re(x[col])
    MS_ALPHA_CIM = 3'd1,  // alpha * im(x[col]), negated on use
    MS_XR_TR     = 3'd2,
    MS_XI_TR     = 3'd3,
    MS_XR_TI     = 3'd4,
    MS_XI_TI     = 3'd5,
    MS_IDLE      = 3'd6   // no product; drains the last one
  } mac_step_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic      start;  // load accumulators with the matrix element
    mac_step_t step;
  } mac_ctl_t;

  localparam logic signed [ACC_W-1:0] WORD_MAX_EXT =
    {{(ACC_W-WORD_W){1'b0}}, 1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] WORD_MIN_EXT =
    {{(ACC_W-WORD_W){1'b1}}, 1'b1, {(WORD_W-1){1'b0}}};

  // Clamp a wide signed value to one data word
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > WORD_MAX_EXT) r = WORD_MAX_EXT[WORD_W-1:0];
    else if (v < WORD_MIN_EXT) r = WORD_MIN_EXT[WORD_W-1:0];
    else r = v[WORD_W-1:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/hpr_if.sv
// Valid/ready channel interfaces for update items and result items.
interface hpr_req_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [5:0]         row_index;
  logic [5:0]         col_index;
  logic signed [31:0] value_re;
  logic signed [31:0] value_im;
  logic               final_element;

  modport source (output valid, operation, row_index, col_index, value_re, value_im,
                  final_element, input ready);
  modport sink   (input valid, operation, row_index, col_index, value_re, value_im,
                  final_element, output ready);
endinterface

interface hpr_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_re;
  logic signed [31:0] result_im;
  logic               result_last;
  logic               bad_position;

  modport source (output valid, result_re, result_im, result_last, bad_position,
                  input ready);
  modport sink   (input valid, result_re, result_im, result_last, bad_position,
                  output ready);
endinterface

// File: hw/rtl/hpr_xmem.sv
// Complex vector store: one write port, two registered read ports.
module hpr_xmem import hpr_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  input  logic [IDX_W-1:0]   raddr_a,
  input  logic [IDX_W-1:0]   raddr_b,
  output logic [ENTRY_W-1:0] rdata_a,
  output logic [ENTRY_W-1:0] rdata_b
);

  logic [ENTRY_W-1:0] mem [MAX_ORDER];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hw/rtl/hpr_cmac.sv
// Shared-multiplier complex datapath: alpha*conj(x[col]), times x[row], plus A.
module hpr_cmac import hpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [WORD_W-1:0] alpha,
  input  logic signed [WORD_W-1:0] init_re,
  input  logic signed [WORD_W-1:0] init_im,
  input  logic signed [WORD_W-1:0] col_re,
  input  logic signed [WORD_W-1:0] col_im,
  input  logic signed [WORD_W-1:0] row_re,
  input  logic signed [WORD_W-1:0] row_im,
  output logic signed [WORD_W-1:0] sum_re,
  output logic signed [WORD_W-1:0] sum_im
);

  logic signed [WORD_W-1:0] op_a;
  logic signed [WORD_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_neg;
  logic signed [ACC_W-1:0]  sh;
  logic signed [ACC_W-1:0]  sh_neg;
  mac_step_t                pstep;
  logic signed [WORD_W-1:0] tr;
  logic signed [WORD_W-1:0] ti;
  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;

  // Operand select for the one multiplier
  always_comb begin
    unique case (ctl.step)
      MS_ALPHA_CRE: begin op_a = alpha;  op_b = col_re; end
      MS_ALPHA_CIM: begin op_a = alpha;  op_b = col_im; end
      MS_XR_TR:     begin op_a = row_re; op_b = tr;     end
      MS_XI_TR:     begin op_a = row_im; op_b = tr;     end
      MS_XR_TI:     begin op_a = row_re; op_b = ti;     end
      MS_XI_TI:     begin op_a = row_im; op_b = ti;     end
      default:      begin op_a = '0;     op_b = '0;     end
    endcase
  end

  // Floor shift of the registered product
  assign prod_neg = -prod;
  assign sh       = ACC_W'($signed(prod[PROD_W-1:FRAC_BITS]));
  assign sh_neg   = ACC_W'($signed(prod_neg[PROD_W-1:FRAC_BITS]));

  // Product register, tagged with the step that made it
  always_ff @(posedge clk) begin
    if (rst) begin
      pstep <= MS_IDLE;
    end else begin
      pstep <= ctl.step;
    end
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  // Consume the previous product
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_re <= ACC_W'(init_re);
      acc_im <= ACC_W'(init_im);
    end else begin
      unique case (pstep)
        MS_ALPHA_CRE: tr <= sat_word(sh);
        MS_ALPHA_CIM: ti <= sat_word(sh_neg);
        MS_XR_TR:     acc_re <= acc_re + sh;
        MS_XI_TR:     acc_im <= acc_im + sh;
        MS_XR_TI:     acc_im <= acc_im + sh;
        MS_XI_TI:     acc_re <= acc_re - sh;
        default:      ;
      endcase
    end
  end

  assign sum_re = sat_word(acc_re);
  assign sum_im = sat_word(acc_im);

endmodule

// File: hw/rtl/hermitian_packed_rank1_update.sv
// Top level: Hermitian packed rank-1 update A := alpha*x*x^H + A, one element per item.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    operation, row_index, col_index, value_re/im, final_element
//   rsp      out  valid/ready    result_re/im, result_last, bad_position
//   cfg      in   cfg_we         cfg_index, cfg_data (write only)
//
// A load item is taken in the idle state. An update that is bad or has alpha zero goes
// straight to the final step; any other update reads the vector store, runs six products
// plus a drain through the single shared 32x32 multiplier, then loads the output.
// Reset (rst, synchronous) clears config, control and the output valid; no clearing pass.
// The output register lets the next item be accepted while a result waits; a stalled
// result holds the sequencer in its final step until the output frees.
module hermitian_packed_rank1_update import hpr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  hpr_req_if.sink              req,
  hpr_rsp_if.source            rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_t;

  localparam logic [2:0] LAST_STEP = 3'(MS_IDLE);

  // Configuration
  logic                     lower_triangle;
  logic [ORDER_W-1:0]       order;
  logic signed [WORD_W-1:0] alpha;
  logic                     x_reversed;

  // Sequencer and held item
  state_t                   state;
  logic [2:0]               step_cnt;
  logic signed [WORD_W-1:0] val_re;
  logic signed [WORD_W-1:0] val_im;
  logic                     item_last;
  logic                     item_bad;
  logic                     item_skip;
  logic                     item_diag;

  // Output register
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_re;
  logic signed [WORD_W-1:0] out_im;
  logic                     out_last;
  logic                     out_bad;

  logic [ORDER_W-1:0]       n_eff;
  logic [ORDER_W-1:0]       row_ext;
  logic [ORDER_W-1:0]       col_ext;
  logic                     accept;
  logic                     acc_load;
  logic                     acc_upd;
  logic                     pos_bad;
  logic                     load_skip;
  logic [IDX_W-1:0]         load_idx;
  logic                     mem_we;
  logic [ENTRY_W-1:0]       col_entry;
  logic [ENTRY_W-1:0]       row_entry;
  mac_ctl_t                 ctl;
  logic signed [WORD_W-1:0] sum_re;
  logic signed [WORD_W-1:0] sum_im;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_triangle <= 1'b0;
      order          <= '0;
      alpha          <= '0;
      x_reversed     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOWER_TRIANGLE: lower_triangle <= cfg_data[0];
        CFG_ORDER:          order          <= cfg_data[ORDER_W-1:0];
        CFG_ALPHA:          alpha          <= cfg_data;
        CFG_X_REVERSED:     x_reversed     <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  // Item decode
  assign n_eff    = (order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order;
  assign row_ext  = ORDER_W'(req.row_index);
  assign col_ext  = ORDER_W'(req.col_index);
  assign req.ready = (state == ST_IDLE);
  assign accept   = req.valid && req.ready;
  assign acc_load = accept && (req.operation == OP_LOAD);
  assign acc_upd  = accept && (req.operation == OP_UPDATE);

  assign pos_bad = (row_ext >= n_eff) || (col_ext >= n_eff) ||
                   (lower_triangle ? (req.row_index < req.col_index)
                                   : (req.row_index > req.col_index));

  // Reversed loads map k to n-1-k; out-of-range ones are dropped
  assign load_skip = x_reversed && (row_ext >= n_eff);
  assign load_idx  = x_reversed ? IDX_W'(n_eff - ORDER_W'(1) - row_ext) : req.row_index;
  assign mem_we    = acc_load && !load_skip;

  hpr_xmem u_xmem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (load_idx),
    .wdata   ({req.value_re, req.value_im}),
    .re      (acc_upd),
    .raddr_a (req.col_index),
    .raddr_b (req.row_index),
    .rdata_a (col_entry),
    .rdata_b (row_entry)
  );

  assign ctl.start = acc_upd;
  assign ctl.step  = (state == ST_CALC) ? mac_step_t'(step_cnt) : MS_IDLE;

  hpr_cmac u_cmac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .alpha   (alpha),
    .init_re (req.value_re),
    .init_im (req.value_im),
    .col_re  (col_entry[ENTRY_W-1:WORD_W]),
    .col_im  (col_entry[WORD_W-1:0]),
    .row_re  (row_entry[ENTRY_W-1:WORD_W]),
    .row_im  (row_entry[WORD_W-1:0]),
    .sum_re  (sum_re),
    .sum_im  (sum_im)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the final step a taken result is replaced by the new one below
      if (rsp.valid && rsp.ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc_upd) begin
            val_re    <= req.value_re;
            val_im    <= req.value_im;
            item_last <= req.final_element;
            item_bad  <= pos_bad;
            item_skip <= pos_bad || (alpha == '0);
            item_diag <= (req.row_index == req.col_index);
            step_cnt  <= '0;
            state     <= (pos_bad || (alpha == '0)) ? ST_FINISH : ST_CALC;
          end
        end
        ST_CALC: begin
          step_cnt <= step_cnt + 3'd1;
          if (step_cnt == LAST_STEP) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_re    <= item_skip ? val_re : sum_re;
            out_im    <= item_skip ? val_im : (item_diag ? '0 : sum_im);
            out_last  <= item_last;
            out_bad   <= item_bad;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_re    = out_re;
  assign rsp.result_im    = out_im;
  assign rsp.result_last  = out_last;
  assign rsp.bad_position = out_bad;

  // A new result only comes out of the final step
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the final step");

  // Store write and read never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && acc_upd))
    else $error("vector store written and read in one cycle");

  // Multiply sequence starts right after an accepted update
  a_calc_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC && step_cnt == 3'd0) |-> $past(acc_upd))
    else $error("multiply sequence began without an update item");

  // Flagged positions never go through the multiplier
  a_bad_skips_calc: assert property (@(posedge clk) disable iff (rst)
    (acc_upd && pos_bad) |=> (state == ST_FINISH))
    else $error("bad position entered the multiply sequence");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the Hermitian packed rank-1 update block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hpr_pkg::*;

  localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] Q_ONE = 32'sh0100_0000;
  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 45;

  typedef struct packed {
    logic                     operation;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [WORD_W-1:0] value_re;
    logic signed [WORD_W-1:0] value_im;
    logic                     final_element;
  } elem_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] re;
    logic signed [WORD_W-1:0] im;
    logic                     last;
    logic                     bad;
  } elem_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  hpr_req_if req_ch ();
  hpr_rsp_if rsp_ch ();

  hermitian_packed_rank1_update u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow copy of the vector store and the registers
  logic signed [WORD_W-1:0] x_re_shadow [MAX_ORDER];
  logic signed [WORD_W-1:0] x_im_shadow [MAX_ORDER];
  logic                     lower_cfg;
  logic [ORDER_W-1:0]       order_cfg;
  logic signed [WORD_W-1:0] alpha_cfg;
  logic                     rev_cfg;

  elem_result_t expected_elems [$];

  int  error_count;
  int  checked_count;
  int  load_count;
  int  update_count;
  int  bad_count;
  int  diag_count;
  int  setting_count;
  bit  send_gaps;
  bit  recv_gaps;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned active_order();
    return (order_cfg > MAX_ORDER) ? MAX_ORDER : order_cfg;
  endfunction

  function automatic logic signed [WORD_W-1:0] clamp_word(input longint v);
    if (v > WORD_HI) return Q_MAX;
    if (v < WORD_LO) return Q_MIN;
    return v[WORD_W-1:0];
  endfunction

  // Arithmetic shift rounds toward minus infinity
  function automatic longint fx_shift(input longint v);
    return v >>> FRAC_BITS;
  endfunction

  // Updated element: A + alpha * x[row] * conj(x[col])
  function automatic elem_result_t predict_element(input elem_item_t it);
    int unsigned  n, row, col;
    longint       tr, ti, xr, xi, pr, pi;
    elem_result_t r;
    n   = active_order();
    row = 32'(it.row_index);
    col = 32'(it.col_index);
    r.re   = it.value_re;
    r.im   = it.value_im;
    r.last = it.final_element;
    r.bad  = (row >= n) || (col >= n) || (lower_cfg ? (row < col) : (row > col));
    if (!r.bad && alpha_cfg != 0) begin
      tr = longint'(clamp_word(fx_shift(longint'(alpha_cfg) * longint'(x_re_shadow[col]))));
      ti = longint'(clamp_word(fx_shift(-(longint'(alpha_cfg) *
                                          longint'(x_im_shadow[col])))));
      xr = longint'(x_re_shadow[row]);
      xi = longint'(x_im_shadow[row]);
      pr = fx_shift(xr * tr) - fx_shift(xi * ti);
      pi = fx_shift(xr * ti) + fx_shift(xi * tr);
      r.re = clamp_word(longint'(it.value_re) + pr);
      if (row == col) r.im = '0;
      else r.im = clamp_word(longint'(it.value_im) + pi);
    end
    return r;
  endfunction

  // Load into the shadow store; reversed loads past the order are dropped
  function automatic void store_x_entry(input elem_item_t it);
    int unsigned n, idx;
    n   = active_order();
    idx = 32'(it.row_index);
    if (rev_cfg) begin
      if (idx >= n) return;
      idx = n - 1 - idx;
    end
    if (idx >= MAX_ORDER) return;
    x_re_shadow[idx] = it.value_re;
    x_im_shadow[idx] = it.value_im;
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return int'($urandom_range(0, 134217728)) - 67108864;
      7:          return Q_MAX;
      8:          return Q_MIN;
      default:    return int'($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  function automatic elem_item_t make_item(input logic op, input int unsigned row,
                                           input int unsigned col,
                                           input logic signed [WORD_W-1:0] re,
                                           input logic signed [WORD_W-1:0] im,
                                           input logic last);
    elem_item_t it;
    it.operation     = op;
    it.row_index     = IDX_W'(row);
    it.col_index     = IDX_W'(col);
    it.value_re      = re;
    it.value_im      = im;
    it.final_element = last;
    return it;
  endfunction

  // Mostly in-triangle updates, some loads, some arbitrary positions
  function automatic elem_item_t random_item();
    elem_item_t  it;
    int unsigned n, a, b, t;
    n = active_order();
    it = make_item(($urandom_range(0, 4) == 0) ? OP_LOAD : OP_UPDATE,
                   $urandom_range(0, MAX_ORDER-1), $urandom_range(0, MAX_ORDER-1),
                   rand_word(), rand_word(), $urandom_range(0, 7) == 0);
    if (it.operation == OP_LOAD) begin
      if (n > 0 && $urandom_range(0, 5) != 0) it.row_index = IDX_W'($urandom_range(0, n-1));
    end else if (n > 0 && $urandom_range(0, 4) != 0) begin
      a = $urandom_range(0, n-1);
      b = $urandom_range(0, n-1);
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      if ($urandom_range(0, 7) == 0) b = a;
      it.row_index = IDX_W'(lower_cfg ? b : a);
      it.col_index = IDX_W'(lower_cfg ? a : b);
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 50)
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Drive one item from a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input elem_item_t it);
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = gap_cycles();
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.operation     = it.operation;
    req_ch.row_index     = it.row_index;
    req_ch.col_index     = it.col_index;
    req_ch.value_re      = it.value_re;
    req_ch.value_im      = it.value_im;
    req_ch.final_element = it.final_element;
    req_ch.valid         = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    if (it.operation == OP_UPDATE) begin
      expected_elems.push_back(predict_element(it));
      update_count++;
      if (expected_elems[$].bad) bad_count++;
      if (it.row_index == it.col_index) diag_count++;
    end else begin
      store_x_entry(it);
      load_count++;
    end
    @(negedge clk);
  endtask

  // Wait until every result is in and the pipeline is quiet
  task automatic drain_results();
    int c;
    req_ch.valid = 1'b0;
    for (c = 0; c < DRAIN_LIMIT && expected_elems.size() != 0; c++) @(posedge clk);
    if (expected_elems.size() != 0) begin
      report_mismatch("items never answered", expected_elems.size(), 0);
      expected_elems.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_config(input int unsigned lower, input int unsigned ord,
                            input logic signed [WORD_W-1:0] alpha, input int unsigned rev);
    drain_results();
    write_reg(CFG_LOWER_TRIANGLE, WORD_W'(lower));
    write_reg(CFG_ORDER, WORD_W'(ord));
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_X_REVERSED, WORD_W'(rev));
    lower_cfg = 1'(lower);
    order_cfg = ORDER_W'(ord);
    alpha_cfg = alpha;
    rev_cfg   = 1'(rev);
    setting_count++;
  endtask

  // Result sink with random stalls
  initial begin : result_sink
    int hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp_ch.ready = 1'b0;
        hold--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (recv_gaps && $urandom_range(0, 4) == 0) hold = gap_cycles();
      end
    end
  end

  // Compare each result with the oldest expected element
  always @(posedge clk) begin : result_check
    elem_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_elems.size() == 0) begin
        report_mismatch("result with no item pending", rsp_ch.result_re, 0);
      end else begin
        want = expected_elems.pop_front();
        checked_count++;
        check_field("result_re", rsp_ch.result_re, want.re);
        check_field("result_im", rsp_ch.result_im, want.im);
        check_field("result_last", 32'(rsp_ch.result_last), 32'(want.last));
        check_field("bad_position", 32'(rsp_ch.bad_position), 32'(want.bad));
      end
    end
  end

  // Registers at reset: order zero makes every update a bad pass-through
  task automatic test_reset_state();
    send_item(make_item(OP_UPDATE, 0, 0, Q_MAX, Q_MIN, 1'b1));
    send_item(make_item(OP_UPDATE, MAX_ORDER-1, MAX_ORDER-1, Q_MIN, Q_MAX, 1'b0));
    drain_results();
  endtask

  // Fill the whole vector store so that no later read hits an unwritten entry
  task automatic test_x_load();
    int k;
    send_item(make_item(OP_LOAD, 0, 0, Q_MAX, Q_MAX, 1'b0));
    send_item(make_item(OP_LOAD, 1, 0, Q_MIN, Q_MAX, 1'b0));
    send_item(make_item(OP_LOAD, 2, 0, Q_ONE, 0, 1'b1));
    for (k = 3; k < MAX_ORDER - 1; k++)
      send_item(make_item(OP_LOAD, k, $urandom_range(0, MAX_ORDER-1),
                          rand_word(), rand_word(), 1'($urandom_range(0, 1))));
    send_item(make_item(OP_LOAD, MAX_ORDER-1, MAX_ORDER-1, Q_MIN, Q_MIN, 1'b0));
  endtask

  // Triangles, diagonal, saturation, alpha zero, reversed loads out of range
  task automatic test_special_cases();
    set_config(1'b0, MAX_ORDER, Q_MAX, 1'b0);
    send_item(make_item(OP_UPDATE, 0, 0, Q_MAX, 32'sh0000_1234, 1'b0));
    send_item(make_item(OP_UPDATE, 0, MAX_ORDER-1, Q_MIN, Q_MAX, 1'b0));
    send_item(make_item(OP_UPDATE, MAX_ORDER-1, 0, Q_MAX, Q_MIN, 1'b0));
    send_item(make_item(OP_UPDATE, MAX_ORDER-1, MAX_ORDER-1, 0, Q_MIN, 1'b1));
    send_item(make_item(OP_UPDATE, 1, 2, Q_ONE, -Q_ONE, 1'b0));

    set_config(1'b1, MAX_ORDER, Q_MIN, 1'b0);
    send_item(make_item(OP_UPDATE, MAX_ORDER-1, 0, Q_MIN, Q_MAX, 1'b0));
    send_item(make_item(OP_UPDATE, 0, MAX_ORDER-1, Q_MAX, Q_MAX, 1'b0));
    send_item(make_item(OP_UPDATE, 1, 1, Q_MIN, Q_MIN, 1'b0));
    send_item(make_item(OP_UPDATE, 2, 1, Q_MAX, Q_MIN, 1'b1));

    set_config(1'b0, MAX_ORDER, 0, 1'b0);
    send_item(make_item(OP_UPDATE, 5, 5, Q_ONE, 32'sh0123_4567, 1'b0));
    send_item(make_item(OP_UPDATE, 9, 3, Q_MIN, Q_MAX, 1'b1));

    set_config(1'b0, 8, Q_ONE, 1'b1);
    send_item(make_item(OP_LOAD, 9, 0, Q_MAX, Q_MAX, 1'b0));
    send_item(make_item(OP_LOAD, 0, 0, 32'sh0200_0000, -Q_ONE, 1'b0));
    send_item(make_item(OP_LOAD, 7, 0, -Q_ONE, 32'sh0080_0000, 1'b0));
    send_item(make_item(OP_UPDATE, 0, 7, Q_ONE, Q_ONE, 1'b0));
    send_item(make_item(OP_UPDATE, 7, 7, 0, Q_ONE, 1'b0));
    send_item(make_item(OP_UPDATE, 8, 8, Q_ONE, Q_ONE, 1'b0));
    send_item(make_item(OP_UPDATE, 3, 12, Q_MAX, Q_MIN, 1'b1));
  endtask

  // Random items over a series of register settings, extremes first
  task automatic test_random_phases();
    int p, k;
    for (p = 0; p < RAND_PHASES; p++) begin
      send_gaps = (p % 4 != 1);
      recv_gaps = (p % 4 != 2);
      case (p)
        0:       set_config(1'b0, MAX_ORDER, rand_word(), 1'b0);
        1:       set_config(1'b1, MAX_ORDER, rand_word(), 1'b0);
        2:       set_config(1'b0, MAX_ORDER, 0, 1'b1);
        3:       set_config(1'b1, 1, Q_MAX, 1'b1);
        4:       set_config(1'b0, 100, Q_MIN, 1'b0);
        5:       set_config(1'b1, 37, rand_word(), 1'b1);
        6:       set_config(1'b0, 0, rand_word(), 1'b0);
        7:       set_config(1'b1, MAX_ORDER, rand_word(), 1'b1);
        default: set_config($urandom_range(0, 1), $urandom_range(0, MAX_ORDER),
                            rand_word(), $urandom_range(0, 1));
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) send_item(random_item());
    end
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = CFG_LOWER_TRIANGLE;
    cfg_data             = '0;
    req_ch.valid         = 1'b0;
    req_ch.operation     = OP_LOAD;
    req_ch.row_index     = '0;
    req_ch.col_index     = '0;
    req_ch.value_re      = '0;
    req_ch.value_im      = '0;
    req_ch.final_element = 1'b0;
    lower_cfg            = 1'b0;
    order_cfg            = '0;
    alpha_cfg            = '0;
    rev_cfg              = 1'b0;
    send_gaps            = 1'b0;
    recv_gaps            = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_x_load();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    test_special_cases();
    test_random_phases();
    drain_results();

    $display("Checked %0d results from %0d updates and %0d vector loads over %0d settings;",
             checked_count, update_count, load_count, setting_count);
    $display("%0d of the updates were bad positions and %0d were diagonal elements.",
             bad_count, diag_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/hpr_pkg.sv
hw/rtl/hpr_if.sv
hw/rtl/hpr_xmem.sv
hw/rtl/hpr_cmac.sv
hw/rtl/hermitian_packed_rank1_update.sv
verif/testbench.sv
